[design/c_like_lexical_scanner_assert.svh]
// assertion macros for the scanner checker
`ifndef C_LIKE_LEXICAL_SCANNER_ASSERT_SVH
`define C_LIKE_LEXICAL_SCANNER_ASSERT_SVH

// same-cycle implication, masked during reset
`define CLS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("scanner check failed");

// next-cycle implication, masked during reset
`define CLS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("scanner check failed");

// next-cycle implication that also holds across reset
`define CLS_ASSERT_RST(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("scanner check failed");

`endif

[design/cls_pkg.sv]
package cls_pkg;

  localparam int MAX_TEXT = 512;

  localparam logic [5:0] K_STRING = 6'd24;
  localparam logic [5:0] K_NUMBER = 6'd25;
  localparam logic [5:0] K_IDENT  = 6'd26;
  localparam logic [5:0] K_KW0    = 6'd27;
  localparam logic [5:0] K_END    = 6'd40;
  localparam logic [5:0] K_ERROR  = 6'd41;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [7:0] PUNCT [13] = '{
    8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h2c, 8'h2e, 8'h2d, 8'h2b, 8'h2a, 8'h2f, 8'h3b
  };

  // pending operator codes: 1 bar, 2 amp, 3 bang, 4 eq, 5 lt, 6 gt
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_BAD  = 3'd7;
  localparam logic [7:0] OP_FIRST  [8] = '{
    8'h00, 8'h7c, 8'h26, 8'h21, 8'h3d, 8'h3c, 8'h3e, 8'h00
  };
  localparam logic [7:0] OP_SECOND [8] = '{
    8'h00, 8'h7c, 8'h26, 8'h3d, 8'h3d, 8'h3d, 8'h3d, 8'h00
  };
  localparam logic [5:0] OP_PAIR   [8] = '{
    6'd0, 6'd13, 6'd14, 6'd16, 6'd18, 6'd20, 6'd22, K_ERROR
  };
  localparam logic [5:0] OP_SINGLE [8] = '{
    6'd0, K_ERROR, 6'd15, 6'd17, 6'd19, 6'd21, 6'd23, K_ERROR
  };

  localparam logic [47:0] KW_TEXT [13] = '{
    48'("true"), 48'("false"), 48'("while"), 48'("if"), 48'("else"), 48'("int"),
    48'("return"), 48'("const"), 48'("class"), 48'("for"), 48'("void"), 48'("char"),
    48'("long")
  };
  localparam logic [2:0] KW_LEN [13] = '{
    3'd4, 3'd5, 3'd5, 3'd2, 3'd4, 3'd3, 3'd6, 3'd5, 3'd5, 3'd3, 3'd4, 3'd4, 3'd4
  };

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_OPER  = 8'b0000_0010,
    S_STR   = 8'b0000_0100,
    S_NUM   = 8'b0000_1000,
    S_WORD  = 8'b0001_0000,
    S_LSTR  = 8'b0010_0000,
    S_LNUM  = 8'b0100_0000,
    S_LWORD = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [30:0] number_value;
    logic [31:0] text_start;
    logic [9:0]  text_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } res_t;

endpackage

[design/cls_if.sv]
interface cls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;
  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface cls_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [30:0] number_value;
  logic [31:0] text_start;
  logic [9:0]  text_length;
  logic [15:0] line_number;
  logic        last_of_run;
  modport source (output valid, output token_kind, output number_value, output text_start,
                  output text_length, output line_number, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input number_value, input text_start,
                input text_length, input line_number, input last_of_run, output ready);
endinterface

[design/c_like_lexical_scanner.sv]
// Tokenizer for a small C-like language, one source byte per input beat. Each
// byte is scanned in the cycle it is taken and its tokens (none, one or two)
// go into a four-entry result queue, which sends one token per cycle while the
// sink is ready. A new byte is taken whenever the queue has two free entries,
// so the scanner runs at one byte per cycle while the sink takes results; a byte
// that yields two tokens (it closes a pending token and is itself a one-byte
// token or an error, or it ends the input while a token is pending) takes two
// entries. Identifiers and strings are reported by start offset and length,
// numbers by value (saturated at 2^31-1), and an end-of-input beat flushes any
// pending token, sends the end token and returns the scanner to its reset state.
module c_like_lexical_scanner import cls_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  cls_in_if.sink        in_bus,
  cls_out_if.source     out_bus
);

  res_t       res0, res1;
  logic [1:0] res_cnt;
  logic       take, pop;
  res_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  res_t       head;

  assign in_bus.ready = (cnt_r <= 3'd2);
  assign take = in_bus.valid && in_bus.ready;
  assign pop  = out_bus.valid && out_bus.ready;

  cls_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .char_code    (in_bus.char_code),
    .end_of_input (in_bus.end_of_input),
    .res0         (res0),
    .res1         (res1),
    .res_cnt      (res_cnt)
  );

  always_ff @(posedge clk) begin
    if (take && res_cnt != 2'd0) q_r[wp_r] <= res0;
    if (take && res_cnt == 2'd2) q_r[wp_r + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (take) wp_r <= wp_r + res_cnt;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + (take ? {1'b0, res_cnt} : 3'd0) - {2'd0, pop};
    end
  end

  assign head = q_r[rp_r];
  assign out_bus.valid        = (cnt_r != 3'd0);
  assign out_bus.token_kind   = head.token_kind;
  assign out_bus.number_value = head.number_value;
  assign out_bus.text_start   = head.text_start;
  assign out_bus.text_length  = head.text_length;
  assign out_bus.line_number  = head.line_number;
  assign out_bus.last_of_run  = head.last_of_run;

endmodule

[design/cls_scan.sv]
module cls_scan import cls_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] res_cnt
);

  localparam logic [9:0] MAXT = 10'(MAX_TEXT);

  mode_t       mode_r, mode_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [47:0] kwin_r, kwin_nxt;
  logic [9:0]  tcnt_r, tcnt_nxt;
  logic [31:0] tstart_r, tstart_nxt;
  logic [31:0] bpos_r, bpos_nxt;
  logic [15:0] lines_r, lines_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        dot_r, dot_nxt;

  function automatic res_t mk(logic [5:0] k, logic [30:0] v, logic [31:0] s,
                              logic [9:0] l, logic [15:0] ln);
    res_t r;
    r.token_kind   = k;
    r.number_value = v;
    r.text_start   = s;
    r.text_length  = l;
    r.line_number  = ln;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  logic [5:0]  wkind;
  logic        fl_v, a_v, b_v, do_idle, is_dig, is_alpha, found;
  res_t        fl_r, a_r, b_r;
  mode_t       gmode;
  logic [9:0]  gcnt;
  logic [34:0] prod;

  always_comb begin
    wkind = K_IDENT;
    for (int k = 12; k >= 0; k--) begin
      if (tcnt_r == {7'd0, KW_LEN[k]} &&
          (kwin_r & ((48'd1 << (8 * KW_LEN[k])) - 48'd1)) == KW_TEXT[k]) begin
        wkind = K_KW0 + 6'(k);
      end
    end
  end

  always_comb begin
    fl_v = 1'b0;
    fl_r = '0;
    case (mode_r)
      S_OPER: begin
        fl_v = 1'b1;
        fl_r = mk(OP_SINGLE[pend_r], '0, tstart_r, 10'd1, lines_r);
      end
      S_NUM: begin
        fl_v = 1'b1;
        fl_r = mk(K_NUMBER, acc_r, tstart_r, tcnt_r, lines_r);
      end
      S_WORD: begin
        fl_v = 1'b1;
        fl_r = mk(wkind, '0, tstart_r, tcnt_r, lines_r);
      end
      S_STR: begin
        fl_v = 1'b1;
        fl_r = mk(K_ERROR, '0, tstart_r, tcnt_r, lines_r);
      end
      S_LSTR, S_LNUM, S_LWORD: begin
        fl_v = 1'b1;
        fl_r = mk(K_ERROR, '0, tstart_r, MAXT, lines_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    kwin_nxt   = kwin_r;
    tcnt_nxt   = tcnt_r;
    tstart_nxt = tstart_r;
    bpos_nxt   = bpos_r + 32'd1;
    lines_nxt  = lines_r;
    acc_nxt    = acc_r;
    dot_nxt    = dot_r;
    a_v = 1'b0;
    a_r = '0;
    b_v = 1'b0;
    b_r = '0;
    do_idle = 1'b0;
    found = 1'b0;
    is_dig   = char_code inside {[8'h30:8'h39]};
    is_alpha = char_code inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    if (tcnt_r >= MAXT) begin
      gcnt = MAXT;
    end else begin
      gcnt = tcnt_r + 10'd1;
    end
    gmode = mode_r;
    prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {27'd0, char_code - CH_ZERO};

    if (end_of_input) begin
      a_v = fl_v;
      a_r = fl_r;
      b_v = 1'b1;
      b_r = mk(K_END, '0, bpos_r, 10'd0, lines_r);
      mode_nxt   = S_IDLE;
      pend_nxt   = OP_NONE;
      kwin_nxt   = '0;
      tcnt_nxt   = '0;
      tstart_nxt = '0;
      bpos_nxt   = '0;
      lines_nxt  = '0;
      acc_nxt    = '0;
      dot_nxt    = 1'b0;
    end else begin
      case (mode_r)
        S_OPER: begin
          mode_nxt = S_IDLE;
          pend_nxt = OP_NONE;
          if (pend_r != OP_NONE && pend_r != OP_BAD && char_code == OP_SECOND[pend_r]) begin
            b_v = 1'b1;
            b_r = mk(OP_PAIR[pend_r], '0, tstart_r, 10'd2, lines_r);
          end else begin
            a_v = fl_v;
            a_r = fl_r;
            do_idle = 1'b1;
          end
        end
        S_STR, S_LSTR: begin
          if (tcnt_r >= MAXT) gmode = S_LSTR;
          tcnt_nxt = gcnt;
          mode_nxt = gmode;
          if (char_code == CH_QUOTE) begin
            b_v = 1'b1;
            if (gmode == S_STR) begin
              b_r = mk(K_STRING, '0, tstart_r, gcnt, lines_r);
            end else begin
              b_r = mk(K_ERROR, '0, tstart_r, MAXT, lines_r);
            end
            mode_nxt = S_IDLE;
          end
        end
        S_NUM, S_LNUM: begin
          if (is_dig || char_code == CH_DOT) begin
            if (char_code == CH_DOT) begin
              dot_nxt = 1'b1;
            end else if (!dot_r) begin
              acc_nxt = (prod > 35'h7fff_ffff) ? 31'h7fff_ffff : prod[30:0];
            end
            if (tcnt_r >= MAXT) mode_nxt = S_LNUM;
            tcnt_nxt = gcnt;
          end else begin
            a_v = fl_v;
            a_r = fl_r;
            mode_nxt = S_IDLE;
            pend_nxt = OP_NONE;
            do_idle = 1'b1;
          end
        end
        S_WORD, S_LWORD: begin
          if (is_alpha || char_code == CH_UNDER) begin
            kwin_nxt = {kwin_r[39:0], char_code};
            if (tcnt_r >= MAXT) mode_nxt = S_LWORD;
            tcnt_nxt = gcnt;
          end else begin
            a_v = fl_v;
            a_r = fl_r;
            mode_nxt = S_IDLE;
            pend_nxt = OP_NONE;
            do_idle = 1'b1;
          end
        end
        default: begin
          mode_nxt = S_IDLE;
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        if (char_code == CH_SPACE || char_code == CH_CR || char_code == CH_TAB) begin
          found = 1'b1;
        end else if (char_code == CH_NL) begin
          found = 1'b1;
          if (lines_r != 16'hffff) lines_nxt = lines_r + 16'd1;
        end
        for (int k = 0; k < 13; k++) begin
          if (!found && char_code == PUNCT[k]) begin
            found = 1'b1;
            b_v = 1'b1;
            b_r = mk(6'(k), '0, bpos_r, 10'd1, lines_r);
          end
        end
        for (int k = 1; k < 7; k++) begin
          if (!found && char_code == OP_FIRST[k]) begin
            found = 1'b1;
            mode_nxt = S_OPER;
            pend_nxt = 3'(k);
            tstart_nxt = bpos_r;
          end
        end
        if (!found) begin
          tstart_nxt = bpos_r;
          tcnt_nxt = 10'd1;
          if (char_code == CH_QUOTE) begin
            mode_nxt = S_STR;
          end else if (is_dig) begin
            mode_nxt = S_NUM;
            acc_nxt = {23'd0, char_code - CH_ZERO};
            dot_nxt = 1'b0;
          end else if (is_alpha) begin
            mode_nxt = S_WORD;
            kwin_nxt = {40'd0, char_code};
          end else begin
            tcnt_nxt = '0;
            b_v = 1'b1;
            b_r = mk(K_ERROR, '0, bpos_r, 10'd1, lines_r);
          end
        end
      end
    end

    if (a_v) begin
      res0 = a_r;
      res1 = b_r;
      if (b_v) begin
        res1.last_of_run = 1'b1;
      end else begin
        res0.last_of_run = 1'b1;
      end
    end else begin
      res0 = b_r;
      res0.last_of_run = 1'b1;
      res1 = '0;
    end
    res_cnt = {1'b0, a_v} + {1'b0, b_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= S_IDLE;
      pend_r   <= OP_NONE;
      kwin_r   <= '0;
      tcnt_r   <= '0;
      tstart_r <= '0;
      bpos_r   <= '0;
      lines_r  <= '0;
      acc_r    <= '0;
      dot_r    <= 1'b0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      kwin_r   <= kwin_nxt;
      tcnt_r   <= tcnt_nxt;
      tstart_r <= tstart_nxt;
      bpos_r   <= bpos_nxt;
      lines_r  <= lines_nxt;
      acc_r    <= acc_nxt;
      dot_r    <= dot_nxt;
    end
  end

endmodule

[design/cls_checker.sv]
`include "c_like_lexical_scanner_assert.svh"

module cls_checker import cls_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_kind,
  input logic [9:0] out_len,
  input logic       out_last
);

  `CLS_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)
  `CLS_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_kind))
  `CLS_ASSERT_IMP(a_end_last, out_valid && out_kind == K_END, out_last && out_len == 10'd0)
  `CLS_ASSERT_IMP(a_len_max, out_valid, out_len <= 10'(MAX_TEXT) && out_kind <= K_ERROR)

endmodule

bind c_like_lexical_scanner cls_checker u_cls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_kind  (out_bus.token_kind),
  .out_len   (out_bus.text_length),
  .out_last  (out_bus.last_of_run)
);
